>>> src/tltw_pkg.sv
// shared constants and command types for the two-level two-way cache model
`default_nettype none

package tltw_pkg;

  // access fields
  localparam int ADDR_W           = 32;
  localparam int SERVED_W         = 2;
  localparam int LINE_OFFSET_BITS = 6;

  // set counts per hierarchy, both powers of two
  localparam int L1_SETS  = 512;
  localparam int L2_SETS  = 4096;

  // derived geometry: data sets first, then instruction sets
  localparam int L1_SET_W = $clog2(L1_SETS);
  localparam int L2_SET_W = $clog2(L2_SETS);
  localparam int L1_TAG_W = ADDR_W - LINE_OFFSET_BITS - L1_SET_W;
  localparam int L2_TAG_W = ADDR_W - LINE_OFFSET_BITS - L2_SET_W;
  localparam int L1_DEPTH = 2 * L1_SETS;
  localparam int L2_DEPTH = 2 * L2_SETS;
  localparam int L1_IDX_W = $clog2(L1_DEPTH);
  localparam int L2_IDX_W = $clog2(L2_DEPTH);

  // result codes
  localparam logic [SERVED_W-1:0] SERVED_L1   = 2'd0;
  localparam logic [SERVED_W-1:0] SERVED_L2   = 2'd1;
  localparam logic [SERVED_W-1:0] SERVED_MISS = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr;          // write one cleared entry per cycle
    logic rd;           // capture the item and read both tag stores
    logic wr;           // write back updated ways
    logic load_new;     // fresh result into the output register
    logic load_pend;    // fresh result into the pending register
    logic pend_to_out;  // pending result into the output register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> src/tltw_dp.sv
// datapath: tag stores, hit check, way update and result registers
`default_nettype none

module tltw_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tltw_pkg::ctrl_cmd_t            cmd,
  input  wire logic                           in_kind,
  input  wire logic [tltw_pkg::ADDR_W-1:0]    in_addr,
  output logic                                clear_done,
  output logic [tltw_pkg::SERVED_W-1:0]       out_served
);
  import tltw_pkg::*;

  typedef struct packed {
    logic [L1_TAG_W-1:0] tag1;
    logic                vld1;
    logic [L1_TAG_W-1:0] tag0;
    logic                vld0;
  } l1_ways_t;

  typedef struct packed {
    logic [L2_TAG_W-1:0] tag1;
    logic                vld1;
    logic [L2_TAG_W-1:0] tag0;
    logic                vld0;
  } l2_ways_t;

  // tag stores, one entry per set, way 0 most recent
  l1_ways_t l1_mem [L1_DEPTH];
  l2_ways_t l2_mem [L2_DEPTH];

  logic [L2_IDX_W-1:0]  clr_cnt_r;
  logic [L1_IDX_W-1:0]  l1_idx_r;
  logic [L2_IDX_W-1:0]  l2_idx_r;
  logic [L1_TAG_W-1:0]  l1_tag_r;
  logic [L2_TAG_W-1:0]  l2_tag_r;
  l1_ways_t             l1_rd_r;
  l2_ways_t             l2_rd_r;
  logic [SERVED_W-1:0]  out_data_r;
  logic [SERVED_W-1:0]  pend_r;

  logic [ADDR_W-LINE_OFFSET_BITS-1:0] line;
  logic                 l1_hit0, l1_hit1, l1_hit;
  logic                 l2_hit0, l2_hit1, l2_hit;
  l1_ways_t             l1_new, l1_wdata;
  l2_ways_t             l2_new, l2_wdata;
  logic [L1_IDX_W-1:0]  l1_waddr;
  logic [L2_IDX_W-1:0]  l2_waddr;
  logic [SERVED_W-1:0]  served;

  assign line = in_addr[ADDR_W-1:LINE_OFFSET_BITS];

  // clearing pass counter, sweeps the larger store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign clear_done = (clr_cnt_r == L2_IDX_W'(L2_DEPTH - 1));

  // capture the item's set indexes and tags
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      l1_idx_r <= {in_kind, line[L1_SET_W-1:0]};
      l2_idx_r <= {in_kind, line[L2_SET_W-1:0]};
      l1_tag_r <= line[ADDR_W-LINE_OFFSET_BITS-1:L1_SET_W];
      l2_tag_r <= line[ADDR_W-LINE_OFFSET_BITS-1:L2_SET_W];
    end
  end

  // hit check; a swap after a way 1 hit equals an install of the same tag
  always_comb begin
    l1_hit0 = l1_rd_r.vld0 && (l1_rd_r.tag0 == l1_tag_r);
    l1_hit1 = l1_rd_r.vld1 && (l1_rd_r.tag1 == l1_tag_r);
    l1_hit  = l1_hit0 || l1_hit1;
    l2_hit0 = l2_rd_r.vld0 && (l2_rd_r.tag0 == l2_tag_r);
    l2_hit1 = l2_rd_r.vld1 && (l2_rd_r.tag1 == l2_tag_r);
    l2_hit  = l2_hit0 || l2_hit1;

    l1_new = l1_rd_r;
    if (!l1_hit0) begin
      l1_new.tag1 = l1_rd_r.tag0;
      l1_new.vld1 = l1_rd_r.vld0;
      l1_new.tag0 = l1_tag_r;
      l1_new.vld0 = 1'b1;
    end

    // l2 is left alone on an l1 hit
    l2_new = l2_rd_r;
    if (!l1_hit && !l2_hit0) begin
      l2_new.tag1 = l2_rd_r.tag0;
      l2_new.vld1 = l2_rd_r.vld0;
      l2_new.tag0 = l2_tag_r;
      l2_new.vld0 = 1'b1;
    end

    if (l1_hit) begin
      served = SERVED_L1;
    end else if (l2_hit) begin
      served = SERVED_L2;
    end else begin
      served = SERVED_MISS;
    end
  end

  // write port: cleared entries during the sweep, updated ways otherwise
  always_comb begin
    l1_waddr = cmd.clr ? clr_cnt_r[L1_IDX_W-1:0] : l1_idx_r;
    l2_waddr = cmd.clr ? clr_cnt_r : l2_idx_r;
    l1_wdata = cmd.clr ? '0 : l1_new;
    l2_wdata = cmd.clr ? '0 : l2_new;
  end

  // l1 tag store
  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.wr) begin
      l1_mem[l1_waddr] <= l1_wdata;
    end
    if (cmd.rd) begin
      l1_rd_r <= l1_mem[{in_kind, line[L1_SET_W-1:0]}];
    end
  end

  // l2 tag store
  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.wr) begin
      l2_mem[l2_waddr] <= l2_wdata;
    end
    if (cmd.rd) begin
      l2_rd_r <= l2_mem[{in_kind, line[L2_SET_W-1:0]}];
    end
  end

  // output and pending result registers
  always_ff @(posedge clk) begin
    if (cmd.load_new) begin
      out_data_r <= served;
    end else if (cmd.pend_to_out) begin
      out_data_r <= pend_r;
    end
    if (cmd.load_pend) begin
      pend_r <= served;
    end
  end

  assign out_served = out_data_r;

endmodule

`default_nettype wire

>>> src/tltw_ctrl.sv
// controller: clearing pass, lookup and write-back sequence, output handshake
`default_nettype none

module tltw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic                 clear_done,
  output tltw_pkg::ctrl_cmd_t       cmd
);
  import tltw_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    out_free      = !out_valid_r || out_tready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (out_valid_r && out_tready) begin
          out_valid_nxt = 1'b0;
        end
        if (in_tvalid) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.wr = 1'b1;
        if (out_free) begin
          cmd.load_new  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.load_pend = 1'b1;
          state_nxt     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // output register stays full, the pending item moves up
        if (out_tready) begin
          cmd.pend_to_out = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> src/two_level_two_way_cache_model.sv
// top level of the two-level two-way cache model
`default_nettype none

// Looks up each access (in_tuser picks the data or instruction hierarchy,
// in_tdata is the byte address) in a 2-way L1 of 512 sets and a 2-way L2 of
// 4096 sets per hierarchy, 64-byte lines, and returns 0 for an L1 hit, 1 for
// an L2 hit, 2 for a miss at both levels. Each item has a read step and a
// write-back step: the read step reads both tag RAMs at the item's sets
// (registered read), the write-back step writes the reordered or installed
// ways back through the single write port of each RAM, and no new item is
// accepted until that write-back is done. A result waits in an output
// register; a second result held by a stalled consumer sits in a pending
// register and input is held off until it moves up. After reset a clearing
// pass writes every tag RAM entry invalid, with in_tready low throughout.
module two_level_two_way_cache_model (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] address
  input  wire logic        in_tuser,   // [0] kind: 0 data, 1 instruction
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [1:0] served_by, [7:2] zero
);
  import tltw_pkg::*;

  ctrl_cmd_t            cmd;
  logic                 clear_done;
  logic [SERVED_W-1:0]  served;

  tltw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .clear_done (clear_done),
    .cmd        (cmd)
  );

  tltw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_kind    (in_tuser),
    .in_addr    (in_tdata),
    .clear_done (clear_done),
    .out_served (served)
  );

  assign out_tdata = {(8 - SERVED_W)'(0), served};

  // an accepted item blocks input for its write-back cycle
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted during write-back");

  // reset starts the clearing pass, no input taken
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // a fresh result follows an accepted item, loaded in its write-back step
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without an accepted item");

endmodule

`default_nettype wire
